// File: hw/rtl/circle_tangent_points_top_assert.svh
// Assertion macros used by the checker file; clocked on clk, held off during reset.
`ifndef CIRCLE_TANGENT_POINTS_TOP_ASSERT_SVH
`define CIRCLE_TANGENT_POINTS_TOP_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define CTP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("ctp: assertion failed");

// Consequent checked at the edge after the antecedent.
`define CTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("ctp: assertion failed");

`endif

// File: hw/rtl/ctp_pkg.sv
`default_nettype none
package ctp_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	// fraction bits of the two ratios r^2/D2 and r*s/D2
	localparam int QBITS = 62;
endpackage
`default_nettype wire

// File: hw/rtl/circle_tangent_points_top.sv
`default_nettype none
// Tangent points from an external point to a circle. Raise start with a point, a center and a
// radius; the beat is taken at an edge where busy is low. busy is high only in reset and
// the cycle after it, so a new beat can be taken every cycle. Every beat returns exactly one
// result, on a one-cycle done strobe; the receiver cannot hold it off and must take it in
// that cycle. The square root resolves one result bit per stage (COORD_WIDTH + 1 stages),
// and the two ratio dividers resolve one quotient bit per stage (62 stages). valid_res
// is low, and all four coordinates are zero, when the point is not strictly outside the circle.
module circle_tangent_points_top #(
	parameter int COORD_WIDTH = ctp_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic signed [COORD_WIDTH-1:0] center_x,
	input  wire logic signed [COORD_WIDTH-1:0] center_y,
	input  wire logic        [COORD_WIDTH-2:0] radius,
	output logic                               done,
	output logic                               valid_res,
	output logic signed      [COORD_WIDTH-1:0] first_x,
	output logic signed      [COORD_WIDTH-1:0] first_y,
	output logic signed      [COORD_WIDTH-1:0] second_x,
	output logic signed      [COORD_WIDTH-1:0] second_y
);
	import ctp_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int DW  = W + 1;
	localparam int D2W = 2 * W + 1;
	localparam int SW  = W + 1;
	localparam int TW  = D2W + 2;
	localparam int NW  = D2W + 1;
	localparam int QB  = QBITS;
	localparam int QL  = QB / 2;
	localparam int QH  = QB - QL;
	localparam int HB  = (W + 1) / 2;
	localparam int HW  = W - HB;
	localparam int LOW = QL + W + 1;
	localparam int HIW = QH + W + 1;
	localparam int PMW = QB + W;
	localparam int TSW = PMW + 3;
	localparam int OW  = TSW - QB;
	localparam int CW  = OW + 1;
	localparam int SBW = 4 * W + 2;

	localparam int DY_LSB = 0;
	localparam int DX_LSB = DW;
	localparam int CY_LSB = 2 * DW;
	localparam int CX_LSB = 2 * DW + W;

	// product slots
	localparam int AX = 0;
	localparam int AY = 1;
	localparam int BX = 2;
	localparam int BY = 3;

	localparam logic [TSW-1:0] HALF = TSW'(1) << (QB - 1);
	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b1;
		end else begin
			busy <= 1'b0;
		end
	end

	// ---------------- front: offsets, squares, distance ----------------
	logic                 v_s1, v_s2, v_s3;
	logic signed [DW-1:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [W-1:0]  cx_s1, cy_s1, cx_s2, cy_s2;
	logic [W-2:0]         r_s1, r_s2, r_s3;
	logic [2*W-1:0]       dxsq_s2, dysq_s2;
	logic [2*W-3:0]       r2_s2, r2_s3;
	logic [D2W-1:0]       d2_s3;
	logic [SBW-1:0]       sb_s3;
	logic [W-1:0]         dxm, dym;

	assign dxm = dx_s1[DW-1] ? W'(-dx_s1) : W'(dx_s1);
	assign dym = dy_s1[DW-1] ? W'(-dy_s1) : W'(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= DW'(point_x) - DW'(center_x);
		dy_s1   <= DW'(point_y) - DW'(center_y);
		cx_s1   <= center_x;
		cy_s1   <= center_y;
		r_s1    <= radius;
		dxsq_s2 <= (2*W)'(dxm) * (2*W)'(dxm);
		dysq_s2 <= (2*W)'(dym) * (2*W)'(dym);
		r2_s2   <= (2*W-2)'(r_s1) * (2*W-2)'(r_s1);
		dx_s2   <= dx_s1;
		dy_s2   <= dy_s1;
		cx_s2   <= cx_s1;
		cy_s2   <= cy_s1;
		r_s2    <= r_s1;
		d2_s3   <= D2W'(dxsq_s2) + D2W'(dysq_s2);
		r2_s3   <= r2_s2;
		r_s3    <= r_s2;
		sb_s3   <= {cx_s2, cy_s2, dx_s2, dy_s2};
	end

	// ---------------- square root of D2 - r^2, one bit per stage ----------------
	logic [D2W-1:0] rt_rem_s [0:SW];
	logic [SW-1:0]  rt_res_s [0:SW];
	logic [D2W-1:0] rt_d2_s  [0:SW];
	logic [2*W-3:0] rt_r2_s  [0:SW];
	logic [W-2:0]   rt_r_s   [0:SW];
	logic [SBW-1:0] rt_sb_s  [0:SW];
	logic           rt_ok_s  [0:SW];
	logic           rt_v_s   [0:SW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else begin
			rt_v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		rt_rem_s[0] <= d2_s3 - D2W'(r2_s3);
		rt_res_s[0] <= '0;
		rt_d2_s[0]  <= d2_s3;
		rt_r2_s[0]  <= r2_s3;
		rt_r_s[0]   <= r_s3;
		rt_sb_s[0]  <= sb_s3;
		rt_ok_s[0]  <= d2_s3 > D2W'(r2_s3);
	end

	for (genvar k = 0; k < SW; k++) begin : g_rt
		localparam int B = SW - 1 - k;
		logic [TW-1:0] trial;
		logic          take;

		// res holds only bits above B, so 2*res*2^B + 2^2B is a plain OR
		assign trial = (TW'(rt_res_s[k]) << (B + 1)) | (TW'(1) << (2 * B));
		assign take  = TW'(rt_rem_s[k]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rt_rem_s[k+1] <= take ? rt_rem_s[k] - trial[D2W-1:0] : rt_rem_s[k];
			rt_res_s[k+1] <= take ? rt_res_s[k] | (SW'(1) << B) : rt_res_s[k];
			rt_d2_s[k+1]  <= rt_d2_s[k];
			rt_r2_s[k+1]  <= rt_r2_s[k];
			rt_r_s[k+1]   <= rt_r_s[k];
			rt_sb_s[k+1]  <= rt_sb_s[k];
			rt_ok_s[k+1]  <= rt_ok_s[k];
		end
	end

	// ---------------- ratios r^2/D2 and r*s/D2, one quotient bit per stage ----------------
	logic [NW-1:0]  dv_ra_s [0:QB];
	logic [NW-1:0]  dv_rb_s [0:QB];
	logic [QB-1:0]  dv_qa_s [0:QB];
	logic [QB-1:0]  dv_qb_s [0:QB];
	logic [D2W-1:0] dv_d2_s [0:QB];
	logic [SBW-1:0] dv_sb_s [0:QB];
	logic           dv_ok_s [0:QB];
	logic           dv_v_s  [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= rt_v_s[SW];
		end
	end

	always_ff @(posedge clk) begin
		dv_ra_s[0] <= NW'(rt_r2_s[SW]);
		dv_rb_s[0] <= NW'(rt_r_s[SW]) * NW'(rt_res_s[SW]);
		dv_qa_s[0] <= '0;
		dv_qb_s[0] <= '0;
		dv_d2_s[0] <= rt_d2_s[SW];
		dv_sb_s[0] <= rt_sb_s[SW];
		dv_ok_s[0] <= rt_ok_s[SW];
	end

	for (genvar k = 0; k < QB; k++) begin : g_dv
		logic [NW-1:0] na, nb, den;
		logic          ga, gb;

		assign den = NW'(dv_d2_s[k]);
		assign na  = {dv_ra_s[k][NW-2:0], 1'b0};
		assign nb  = {dv_rb_s[k][NW-2:0], 1'b0};
		assign ga  = na >= den;
		assign gb  = nb >= den;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_ra_s[k+1] <= ga ? na - den : na;
			dv_rb_s[k+1] <= gb ? nb - den : nb;
			dv_qa_s[k+1] <= {dv_qa_s[k][QB-2:0], ga};
			dv_qb_s[k+1] <= {dv_qb_s[k][QB-2:0], gb};
			dv_d2_s[k+1] <= dv_d2_s[k];
			dv_sb_s[k+1] <= dv_sb_s[k];
			dv_ok_s[k+1] <= dv_ok_s[k];
		end
	end

	// ---------------- back: products, offsets, saturation, ordering ----------------
	logic signed [DW-1:0] dx_e, dy_e;
	logic [W-1:0]         mdx, mdy;

	assign dx_e = dv_sb_s[QB][DX_LSB +: DW];
	assign dy_e = dv_sb_s[QB][DY_LSB +: DW];
	assign mdx  = dx_e[DW-1] ? W'(-dx_e) : W'(dx_e);
	assign mdy  = dy_e[DW-1] ? W'(-dy_e) : W'(dy_e);

	logic v_s5, v_s6, v_s7, v_s8, v_s9;
	logic ok_s5, ok_s6, ok_s7, ok_s8, ok_s9;
	logic signed [W-1:0] cx_s5, cy_s5, cx_s6, cy_s6, cx_s7, cy_s7, cx_s8, cy_s8;

	logic [QL+HB-1:0]     ll_s5   [0:3];
	logic [QL+HW-1:0]     lh_s5   [0:3];
	logic [QH+HB-1:0]     hl_s5   [0:3];
	logic [QH+HW-1:0]     hh_s5   [0:3];
	logic                 neg_s5  [0:3];
	logic                 neg_s6  [0:3];
	logic [LOW-1:0]       lo_s6   [0:3];
	logic [HIW-1:0]       hi_s6   [0:3];
	logic signed [PMW:0]  term_s7 [0:3];
	logic signed [TSW-1:0] tsum   [0:3];
	logic signed [OW-1:0] off_s8  [0:3];
	logic signed [W-1:0]  pos_s9  [0:3];

	for (genvar j = 0; j < 4; j++) begin : g_mul
		logic [QB-1:0]  qo;
		logic [W-1:0]   mo;
		logic [PMW-1:0] prod;

		assign qo   = (j < 2) ? dv_qa_s[QB] : dv_qb_s[QB];
		assign mo   = (j % 2 == 0) ? mdx : mdy;
		assign prod = PMW'(lo_s6[j]) + (PMW'(hi_s6[j]) << QL);

		always_ff @(posedge clk) begin
			ll_s5[j]   <= (QL+HB)'(qo[QL-1:0]) * (QL+HB)'(mo[HB-1:0]);
			lh_s5[j]   <= (QL+HW)'(qo[QL-1:0]) * (QL+HW)'(mo[W-1:HB]);
			hl_s5[j]   <= (QH+HB)'(qo[QB-1:QL]) * (QH+HB)'(mo[HB-1:0]);
			hh_s5[j]   <= (QH+HW)'(qo[QB-1:QL]) * (QH+HW)'(mo[W-1:HB]);
			neg_s5[j]  <= (j % 2 == 0) ? dx_e[DW-1] : dy_e[DW-1];
			lo_s6[j]   <= LOW'(ll_s5[j]) + (LOW'(lh_s5[j]) << HB);
			hi_s6[j]   <= HIW'(hl_s5[j]) + (HIW'(hh_s5[j]) << HB);
			neg_s6[j]  <= neg_s5[j];
			term_s7[j] <= neg_s6[j] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
		end
	end

	always_comb begin
		tsum[0] = TSW'(term_s7[AX]) - TSW'(term_s7[BY]) + HALF;
		tsum[1] = TSW'(term_s7[AY]) + TSW'(term_s7[BX]) + HALF;
		tsum[2] = TSW'(term_s7[AX]) + TSW'(term_s7[BY]) + HALF;
		tsum[3] = TSW'(term_s7[AY]) - TSW'(term_s7[BX]) + HALF;
	end

	for (genvar i = 0; i < 4; i++) begin : g_pos
		logic signed [W-1:0]  ctr;
		logic signed [CW-1:0] sum;

		assign ctr = (i % 2 == 0) ? cx_s8 : cy_s8;
		assign sum = CW'(ctr) + CW'(off_s8[i]);

		always_ff @(posedge clk) begin
			// round half up: floor of (v + 2^61) / 2^62
			off_s8[i] <= OW'(tsum[i] >>> QB);
			if (sum > CW'(CMAX)) begin
				pos_s9[i] <= CMAX;
			end else if (sum < CW'(CMIN)) begin
				pos_s9[i] <= CMIN;
			end else begin
				pos_s9[i] <= sum[W-1:0];
			end
		end
	end

	logic first_one;
	assign first_one = (pos_s9[0] > pos_s9[2]) ||
		((pos_s9[0] == pos_s9[2]) && (pos_s9[1] >= pos_s9[3]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			done      <= 1'b0;
			valid_res <= 1'b0;
		end else begin
			v_s5      <= dv_v_s[QB];
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			done      <= v_s9;
			valid_res <= v_s9 & ok_s9;
		end
	end

	always_ff @(posedge clk) begin
		cx_s5 <= dv_sb_s[QB][CX_LSB +: W];
		cy_s5 <= dv_sb_s[QB][CY_LSB +: W];
		ok_s5 <= dv_ok_s[QB];
		cx_s6 <= cx_s5;
		cy_s6 <= cy_s5;
		ok_s6 <= ok_s5;
		cx_s7 <= cx_s6;
		cy_s7 <= cy_s6;
		ok_s7 <= ok_s6;
		cx_s8 <= cx_s7;
		cy_s8 <= cy_s7;
		ok_s8 <= ok_s7;
		ok_s9 <= ok_s8;
		// drop coordinates when the point is on or inside the circle
		if (!ok_s9) begin
			first_x  <= '0;
			first_y  <= '0;
			second_x <= '0;
			second_y <= '0;
		end else if (first_one) begin
			first_x  <= pos_s9[0];
			first_y  <= pos_s9[1];
			second_x <= pos_s9[2];
			second_y <= pos_s9[3];
		end else begin
			first_x  <= pos_s9[2];
			first_y  <= pos_s9[3];
			second_x <= pos_s9[0];
			second_y <= pos_s9[1];
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/ctp_checker.sv
`default_nettype none
`include "circle_tangent_points_top_assert.svh"
module ctp_checker #(
	parameter int COORD_WIDTH = ctp_pkg::COORD_WIDTH_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic                          valid_res,
	input wire logic signed [COORD_WIDTH-1:0] first_x,
	input wire logic signed [COORD_WIDTH-1:0] first_y,
	input wire logic signed [COORD_WIDTH-1:0] second_x,
	input wire logic signed [COORD_WIDTH-1:0] second_y
);
	import ctp_pkg::*;

	localparam int LATENCY = 12 + COORD_WIDTH + QBITS;

	// every accepted beat comes back after the fixed pipeline depth
	`CTP_ASSERT_NOW(a_latency, start && !busy, ##LATENCY done)
	`CTP_ASSERT_NOW(a_valid_in_strobe, valid_res, done)
	`CTP_ASSERT_NOW(a_zero_when_inside, done && !valid_res, (first_x | first_y | second_x | second_y) == '0)
	`CTP_ASSERT_NOW(a_order, done && valid_res, first_x > second_x || (first_x == second_x && first_y >= second_y))
	`CTP_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)
endmodule

bind circle_tangent_points_top ctp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ctp_checker (.*);
`default_nettype wire
